### rtl/pidat_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pidat_pkg
// Shared types, constants and the byte-wide CRC-32 step for the IDAT framer.
// ----------------------------------------------------------------------------
package pidat_pkg;

   localparam logic [16:0] BLOCK_MAX  = 17'd65535;
   localparam logic [14:0] MAX_WIDTH  = 15'd16384;
   localparam logic [14:0] MAX_HEIGHT = 15'd16384;
   localparam logic [16:0] ADLER_MOD  = 17'd65521;
   localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = 2;

   typedef enum logic [0:0] {
      REG_WIDTH  = 1'b0,
      REG_HEIGHT = 1'b1
   } reg_index_type;

   typedef enum logic [4:0] {
      PH_HDR  = 5'b00001,
      PH_BLK  = 5'b00010,
      PH_FILT = 5'b00100,
      PH_DATA = 5'b01000,
      PH_TRL  = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [16:0] bpr;
      logic [14:0] height;
      logic [31:0] chunk_len;
   } frame_cfg_type;

   function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

### rtl/pidat_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pidat_req_if / pidat_rsp_if
// Valid/ready channels for pixel bytes in and chunk bytes out.
// ----------------------------------------------------------------------------
interface pidat_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

interface pidat_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;
   logic       chunk_done;
   modport source (output valid, output out_byte, output last_of_run, output chunk_done,
                   input ready);
   modport sink (input valid, input out_byte, input last_of_run, input chunk_done,
                 output ready);
endinterface
`default_nettype wire

### rtl/png_idat_stored_deflate_framer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// png_idat_stored_deflate_framer_unit
// Wraps raw RGBA bytes into one IDAT chunk of stored deflate blocks.
// ----------------------------------------------------------------------------
//  channel | direction | beat contents
//  req     | in        | data_byte
//  rsp     | out       | out_byte, last_of_run, chunk_done
//  csr     | in        | csr_write_en, csr_index, csr_data
//
// One output byte leaves per cycle while rsp is ready and a pixel byte is queued.
// The sequencer puts the chunk and zlib headers before the first byte of a chunk, a
// block header before the first byte of a row or block, the trailer after the last.
// Reset is synchronous; it sets width and height to one and starts a new chunk.
// A stalled rsp holds the output register; req keeps flowing into a four-entry queue until it fills.
module png_idat_stored_deflate_framer_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   pidat_req_if.sink        req,
   pidat_rsp_if.source      rsp,
   input  wire logic        csr_write_en,
   input  wire logic [0:0]  csr_index,
   input  wire logic [14:0] csr_data
);

   logic [14:0] width_ff, width_in;
   logic [14:0] height_ff, height_in;
   logic [14:0] width_c, height_c;
   logic [16:0] per_row;
   logic [31:0] prod;
   pidat_pkg::frame_cfg_type cfg;
   logic        item_valid;
   logic [7:0]  item_byte;
   logic        pop;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write_en) begin
         unique case (pidat_pkg::reg_index_type'(csr_index))
            pidat_pkg::REG_WIDTH:  width_in  = csr_data;
            pidat_pkg::REG_HEIGHT: height_in = csr_data;
            default: width_in = width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 15'd1;
         height_ff <= 15'd1;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign width_c  = (width_ff == '0) ? 15'd1
                   : (width_ff > pidat_pkg::MAX_WIDTH) ? pidat_pkg::MAX_WIDTH : width_ff;
   assign height_c = (height_ff == '0) ? 15'd1
                   : (height_ff > pidat_pkg::MAX_HEIGHT) ? pidat_pkg::MAX_HEIGHT : height_ff;

   // A row holds at most 65537 bytes, so it spans one or two blocks.
   assign cfg.bpr    = {width_c[14:0], 2'b00} + 17'd1;
   assign cfg.height = height_c;
   assign per_row    = cfg.bpr + ((({width_c, 2'b00}) >= pidat_pkg::BLOCK_MAX) ? 17'd10 : 17'd5);
   assign prod       = {17'd0, height_c} * {15'd0, per_row};
   assign cfg.chunk_len = prod + 32'd6;

   pidat_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .pop        (pop),
      .item_valid (item_valid),
      .item_byte  (item_byte)
   );

   pidat_back u_back (
      .clock      (clock),
      .reset      (reset),
      .clear      (csr_write_en),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item_byte  (item_byte),
      .pop        (pop),
      .rsp        (rsp)
   );

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.chunk_done |-> rsp.last_of_run)
      else $error("chunk end without end of run");

   a_pop_has_item: assert property (@(posedge clock) disable iff (reset)
      pop |-> item_valid)
      else $error("queue popped while empty");

   a_pop_makes_last: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp.valid && rsp.last_of_run)
      else $error("item retired without a last beat");

endmodule
`default_nettype wire

### rtl/pidat_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pidat_queue
// Small input queue that accepts pixel beats independently of the back end.
// ----------------------------------------------------------------------------
module pidat_queue (
   input  wire logic   clock,
   input  wire logic   reset,
   pidat_req_if.sink   req,
   input  wire logic   pop,
   output logic        item_valid,
   output logic [7:0]  item_byte
);

   logic [7:0]                     mem_ff [pidat_pkg::QUEUE_DEPTH];
   logic [pidat_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [pidat_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [pidat_pkg::QUEUE_AW:0]   count_ff, count_in;
   logic                           push;
   logic                           take;

   assign req.ready  = (count_ff != (pidat_pkg::QUEUE_AW+1)'(pidat_pkg::QUEUE_DEPTH));
   assign push       = req.valid && req.ready;
   assign item_valid = (count_ff != '0);
   assign item_byte  = mem_ff[rd_ptr_ff];
   assign take       = pop && item_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = take ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !take) begin
         count_in = count_ff + 1'b1;
      end else if (take && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= req.data_byte;
      end
   end

endmodule
`default_nettype wire

### rtl/pidat_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pidat_back
// Byte sequencer: header, block headers, filter and pixel bytes, trailer,
// with running Adler-32 and CRC-32 and a registered output stage.
// ----------------------------------------------------------------------------
module pidat_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     clear,
   input  wire pidat_pkg::frame_cfg_type cfg,
   input  wire logic                     item_valid,
   input  wire logic [7:0]               item_byte,
   output logic                          pop,
   pidat_rsp_if.source                   rsp
);

   pidat_pkg::phase_type ph_ff, ph_in, cur_ph, entry_ph, after_filt_ph;
   logic [3:0]  idx_ff, idx_in, cur_idx;
   logic        busy_ff, busy_in;
   logic [13:0] row_ff, row_in;
   logic [16:0] rbi_ff, rbi_in;
   logic [15:0] bcnt_ff, bcnt_in;
   logic [31:0] crc_ff, crc_in;
   logic [15:0] alo_ff, alo_in;
   logic [15:0] ahi_ff, ahi_in;
   logic        ovalid_ff, ovalid_in;
   logic [7:0]  obyte_ff, obyte_in;
   logic        olast_ff, olast_in;
   logic        odone_ff, odone_in;

   logic        fire;
   logic        start;
   logic [14:0] row_next;
   logic        last_row;
   logic [16:0] remain;
   logic [15:0] blen;
   logic        fin;
   logic [16:0] rbi_p;
   logic [16:0] bcnt_p;
   logic [15:0] bcnt_step;
   logic        row_end;
   logic [7:0]  put_byte;
   logic [16:0] lo_sum, lo_mod, hi_sum, hi_mod;
   logic [31:0] adler;

   function automatic pidat_pkg::phase_type sel_ph(input logic [16:0] rbi, input logic [15:0] bc);
      if (rbi == '0) begin
         return (bc == '0) ? pidat_pkg::PH_BLK : pidat_pkg::PH_FILT;
      end
      return (bc == '0) ? pidat_pkg::PH_BLK : pidat_pkg::PH_DATA;
   endfunction

   assign start    = (row_ff == '0) && (rbi_ff == '0) && (bcnt_ff == '0);
   assign entry_ph = start ? pidat_pkg::PH_HDR : sel_ph(rbi_ff, bcnt_ff);
   assign cur_ph   = busy_ff ? ph_ff : entry_ph;
   assign cur_idx  = busy_ff ? idx_ff : 4'd0;
   assign fire     = item_valid && (!ovalid_ff || rsp.ready);

   assign row_next = {1'b0, row_ff} + 15'd1;
   assign last_row = (row_next >= cfg.height);
   assign remain   = cfg.bpr - rbi_ff;
   assign blen     = (remain <= pidat_pkg::BLOCK_MAX) ? remain[15:0]
                                                      : pidat_pkg::BLOCK_MAX[15:0];
   assign fin      = (remain <= pidat_pkg::BLOCK_MAX) && (row_next == cfg.height);

   assign rbi_p     = rbi_ff + 17'd1;
   assign bcnt_p    = {1'b0, bcnt_ff} + 17'd1;
   assign row_end   = (rbi_p >= cfg.bpr);
   assign bcnt_step = ((bcnt_p >= pidat_pkg::BLOCK_MAX) || row_end) ? 16'd0 : bcnt_p[15:0];
   assign after_filt_ph = sel_ph(rbi_p, bcnt_step);

   assign put_byte = (cur_ph == pidat_pkg::PH_DATA) ? item_byte : 8'd0;
   assign lo_sum   = {1'b0, alo_ff} + {9'd0, put_byte};
   assign lo_mod   = (lo_sum >= pidat_pkg::ADLER_MOD) ? lo_sum - pidat_pkg::ADLER_MOD : lo_sum;
   assign hi_sum   = {1'b0, ahi_ff} + lo_mod;
   assign hi_mod   = (hi_sum >= pidat_pkg::ADLER_MOD) ? hi_sum - pidat_pkg::ADLER_MOD : hi_sum;
   assign adler    = {ahi_ff, alo_ff};

   always_comb begin
      ph_in     = ph_ff;
      idx_in    = idx_ff;
      busy_in   = busy_ff;
      row_in    = row_ff;
      rbi_in    = rbi_ff;
      bcnt_in   = bcnt_ff;
      crc_in    = crc_ff;
      alo_in    = alo_ff;
      ahi_in    = ahi_ff;
      ovalid_in = ovalid_ff && !rsp.ready;
      obyte_in  = obyte_ff;
      olast_in  = olast_ff;
      odone_in  = odone_ff;
      pop       = 1'b0;
      if (fire) begin
         ovalid_in = 1'b1;
         olast_in  = 1'b0;
         odone_in  = 1'b0;
         obyte_in  = 8'd0;
         idx_in    = cur_idx + 4'd1;
         busy_in   = 1'b1;
         ph_in     = cur_ph;
         unique case (cur_ph)
            pidat_pkg::PH_HDR: begin
               case (cur_idx)
                  4'd0: obyte_in = cfg.chunk_len[31:24];
                  4'd1: obyte_in = cfg.chunk_len[23:16];
                  4'd2: obyte_in = cfg.chunk_len[15:8];
                  4'd3: obyte_in = cfg.chunk_len[7:0];
                  4'd4: obyte_in = 8'h49;
                  4'd5: obyte_in = 8'h44;
                  4'd6: obyte_in = 8'h41;
                  4'd7: obyte_in = 8'h54;
                  4'd8: obyte_in = 8'h08;
                  4'd9: obyte_in = 8'h1D;
                  default: obyte_in = 8'd0;
               endcase
               if (cur_idx == 4'd0) begin
                  crc_in = pidat_pkg::CRC_INIT;
                  alo_in = 16'd1;
                  ahi_in = 16'd0;
               end else if (cur_idx >= 4'd4) begin
                  crc_in = pidat_pkg::crc_step(crc_ff, obyte_in);
               end
               if (cur_idx == 4'd9) begin
                  ph_in  = sel_ph(rbi_ff, bcnt_ff);
                  idx_in = 4'd0;
               end
            end
            pidat_pkg::PH_BLK: begin
               case (cur_idx)
                  4'd0: obyte_in = {7'd0, fin};
                  4'd1: obyte_in = blen[7:0];
                  4'd2: obyte_in = blen[15:8];
                  4'd3: obyte_in = ~blen[7:0];
                  4'd4: obyte_in = ~blen[15:8];
                  default: obyte_in = 8'd0;
               endcase
               crc_in = pidat_pkg::crc_step(crc_ff, obyte_in);
               if (cur_idx == 4'd4) begin
                  ph_in  = (rbi_ff == '0) ? pidat_pkg::PH_FILT : pidat_pkg::PH_DATA;
                  idx_in = 4'd0;
               end
            end
            pidat_pkg::PH_FILT, pidat_pkg::PH_DATA: begin
               obyte_in = put_byte;
               crc_in   = pidat_pkg::crc_step(crc_ff, put_byte);
               alo_in   = lo_mod[15:0];
               ahi_in   = hi_mod[15:0];
               rbi_in   = row_end ? 17'd0 : rbi_p;
               bcnt_in  = bcnt_step;
               idx_in   = 4'd0;
               if (cur_ph == pidat_pkg::PH_FILT) begin
                  ph_in = after_filt_ph;
               end else if (row_end && last_row) begin
                  ph_in = pidat_pkg::PH_TRL;
               end else begin
                  busy_in  = 1'b0;
                  olast_in = 1'b1;
                  pop      = 1'b1;
                  if (row_end) begin
                     row_in = row_next[13:0];
                  end
               end
            end
            pidat_pkg::PH_TRL: begin
               case (cur_idx)
                  4'd0: obyte_in = adler[31:24];
                  4'd1: obyte_in = adler[23:16];
                  4'd2: obyte_in = adler[15:8];
                  4'd3: obyte_in = adler[7:0];
                  4'd4: obyte_in = ~crc_ff[31:24];
                  4'd5: obyte_in = ~crc_ff[23:16];
                  4'd6: obyte_in = ~crc_ff[15:8];
                  4'd7: obyte_in = ~crc_ff[7:0];
                  default: obyte_in = 8'd0;
               endcase
               if (cur_idx < 4'd4) begin
                  crc_in = pidat_pkg::crc_step(crc_ff, obyte_in);
               end
               if (cur_idx == 4'd7) begin
                  busy_in  = 1'b0;
                  olast_in = 1'b1;
                  odone_in = 1'b1;
                  pop      = 1'b1;
                  row_in   = '0;
                  rbi_in   = '0;
                  bcnt_in  = '0;
                  idx_in   = 4'd0;
               end
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         ph_ff     <= pidat_pkg::PH_HDR;
         idx_ff    <= '0;
         busy_ff   <= 1'b0;
         row_ff    <= '0;
         rbi_ff    <= '0;
         bcnt_ff   <= '0;
         crc_ff    <= pidat_pkg::CRC_INIT;
         alo_ff    <= 16'd1;
         ahi_ff    <= 16'd0;
      end else begin
         ph_ff     <= ph_in;
         idx_ff    <= idx_in;
         busy_ff   <= busy_in;
         row_ff    <= row_in;
         rbi_ff    <= rbi_in;
         bcnt_ff   <= bcnt_in;
         crc_ff    <= crc_in;
         alo_ff    <= alo_in;
         ahi_ff    <= ahi_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff <= 1'b0;
      end else begin
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      obyte_ff <= obyte_in;
      olast_ff <= olast_in;
      odone_ff <= odone_in;
   end

   assign rsp.valid       = ovalid_ff;
   assign rsp.out_byte    = obyte_ff;
   assign rsp.last_of_run = olast_ff;
   assign rsp.chunk_done  = odone_ff;

endmodule
`default_nettype wire

### verif/png_idat_stored_deflate_framer_unit_checker.sv
// ----------------------------------------------------------------------------
// IDAT framer checker
// Watches the pixel and chunk channels, predicts every chunk byte from the
// accepted pixel bytes and the register writes, and compares beat by beat.
// ----------------------------------------------------------------------------
module png_idat_stored_deflate_framer_unit_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [7:0]  rsp_out_byte,
   input  wire logic        rsp_last_of_run,
   input  wire logic        rsp_chunk_done,
   input  wire logic        csr_write_en,
   input  wire logic [0:0]  csr_index,
   input  wire logic [14:0] csr_data,
   output int               fail_count,
   output int               pending_bytes
);

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       chunk_done;
   } chunk_beat_type;

   chunk_beat_type chunk_bytes_due[$];

   logic [14:0] width_reg, height_reg;
   int unsigned row_num, row_pos, blk_count;
   logic [31:0] crc_acc;
   int unsigned adler_a, adler_b;

   function automatic logic [31:0] crc_update(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      for (int k = 0; k < 8; k++) r = r[0] ? (32'hEDB88320 ^ (r >> 1)) : (r >> 1);
      return r;
   endfunction

   task automatic push_byte(input logic [7:0] b, input bit with_crc, input bit done);
      chunk_beat_type e;
      e.out_byte = b;
      e.last_of_run = 1'b0;
      e.chunk_done = done;
      chunk_bytes_due.push_back(e);
      if (with_crc) crc_acc = crc_update(crc_acc, b);
   endtask

   task automatic push_be32(input logic [31:0] v, input bit with_crc, input bit done);
      push_byte(v[31:24], with_crc, 1'b0);
      push_byte(v[23:16], with_crc, 1'b0);
      push_byte(v[15:8], with_crc, 1'b0);
      push_byte(v[7:0], with_crc, done);
   endtask

   task automatic frame_byte(input logic [7:0] b, input int unsigned bpr,
                             input int unsigned height);
      int unsigned remain, blen;
      bit fin;
      if (blk_count == 0) begin
         remain = bpr - row_pos;
         blen = (remain <= 65535) ? remain : 65535;
         fin = (remain <= 65535) && (row_num + 1 == height);
         push_byte({7'd0, fin}, 1'b1, 1'b0);
         push_byte(blen[7:0], 1'b1, 1'b0);
         push_byte(blen[15:8], 1'b1, 1'b0);
         push_byte(~blen[7:0], 1'b1, 1'b0);
         push_byte(~blen[15:8], 1'b1, 1'b0);
      end
      push_byte(b, 1'b1, 1'b0);
      adler_a = (adler_a + b) % 65521;
      adler_b = (adler_b + adler_a) % 65521;
      row_pos++;
      blk_count++;
      if (blk_count >= 65535 || row_pos >= bpr) blk_count = 0;
   endtask

   task automatic predict_pixel(input logic [7:0] b);
      int unsigned w, h, bpr, nblk;
      logic [63:0] len;
      w = (width_reg == 0) ? 1 : (width_reg > pidat_pkg::MAX_WIDTH) ? pidat_pkg::MAX_WIDTH
                                                                    : width_reg;
      h = (height_reg == 0) ? 1 : (height_reg > pidat_pkg::MAX_HEIGHT) ? pidat_pkg::MAX_HEIGHT
                                                                       : height_reg;
      bpr = w * 4 + 1;
      if (row_num == 0 && row_pos == 0 && blk_count == 0) begin
         nblk = (bpr - 1) / 65535 + 1;
         len = 64'd6 + 64'(h) * (64'(bpr) + 64'(5 * nblk));
         crc_acc = pidat_pkg::CRC_INIT;
         adler_a = 1;
         adler_b = 0;
         push_be32(len[31:0], 1'b0, 1'b0);
         push_byte("I", 1'b1, 1'b0);
         push_byte("D", 1'b1, 1'b0);
         push_byte("A", 1'b1, 1'b0);
         push_byte("T", 1'b1, 1'b0);
         push_byte(8'h08, 1'b1, 1'b0);
         push_byte(8'h1D, 1'b1, 1'b0);
      end
      if (row_pos == 0) frame_byte(8'h00, bpr, h);
      frame_byte(b, bpr, h);
      if (row_pos >= bpr) begin
         row_pos = 0;
         blk_count = 0;
         if (row_num + 1 >= h) begin
            push_be32({adler_b[15:0], adler_a[15:0]}, 1'b1, 1'b0);
            push_be32(~crc_acc, 1'b0, 1'b1);
            row_num = 0;
         end else begin
            row_num = (row_num + 1) & 16'h3FFF;
         end
      end
      chunk_bytes_due[$].last_of_run = 1'b1;
   endtask

   always @(posedge clock) begin
      chunk_beat_type e;
      if (reset) begin
         width_reg <= 15'd1;
         height_reg <= 15'd1;
         row_num = 0; row_pos = 0; blk_count = 0;
         chunk_bytes_due.delete();
         fail_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (chunk_bytes_due.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10) $display("Unexpected chunk beat %h", rsp_out_byte);
            end else begin
               e = chunk_bytes_due.pop_front();
               if (e != {rsp_out_byte, rsp_last_of_run, rsp_chunk_done}) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("Mismatch: expected byte %h last %b done %b, got %h %b %b",
                              e.out_byte, e.last_of_run, e.chunk_done,
                              rsp_out_byte, rsp_last_of_run, rsp_chunk_done);
               end
            end
         end
         if (req_valid && req_ready) predict_pixel(req_data_byte);
         if (csr_write_en) begin
            if (csr_index == pidat_pkg::REG_WIDTH) width_reg <= csr_data;
            else height_reg <= csr_data;
            row_num = 0; row_pos = 0; blk_count = 0;
         end
      end
      pending_bytes <= chunk_bytes_due.size();
   end

endmodule

### verif/tb_png_idat_stored_deflate_framer_unit.sv
// ----------------------------------------------------------------------------
// IDAT framer testbench
// Drives pixel bytes through several image shapes, with random idling on
// both channels and long back-pressure, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_png_idat_stored_deflate_framer_unit;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_en = 1'b0;
   logic [0:0]  csr_index = pidat_pkg::REG_WIDTH;
   logic [14:0] csr_data = '0;
   int          fail_count, pending_bytes;
   int          send_idle_pct = 0, recv_idle_pct = 0;
   bit          hold_off = 1'b0;

   pidat_req_if req ();
   pidat_rsp_if rsp ();

   png_idat_stored_deflate_framer_unit dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_data(csr_data)
   );

   png_idat_stored_deflate_framer_unit_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready), .req_data_byte(req.data_byte),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_out_byte(rsp.out_byte),
      .rsp_last_of_run(rsp.last_of_run), .rsp_chunk_done(rsp.chunk_done),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .pending_bytes(pending_bytes)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp.ready <= !reset && !hold_off && ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic send_pixel(input logic [7:0] b);
      if ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.data_byte <= b;
      do @(posedge clock); while (!req.ready);
   endtask

   task automatic drain;
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending_bytes != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(input pidat_pkg::reg_index_type idx, input logic [14:0] val);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic set_shape(input logic [14:0] w, input logic [14:0] h);
      drain();
      write_csr(pidat_pkg::REG_WIDTH, w);
      write_csr(pidat_pkg::REG_HEIGHT, h);
   endtask

   task automatic send_image(input int unsigned w, input int unsigned h, input int mode);
      for (int unsigned i = 0; i < w * h * 4; i++)
         send_pixel(mode == 0 ? 8'($urandom) : (mode == 1 ? 8'h00 : 8'hFF));
   endtask

   initial begin
      int unsigned w, h;
      req.valid = 1'b0;
      req.data_byte = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_image(1, 1, 1);
      send_image(1, 1, 2);
      set_shape(15'd0, 15'd0);
      send_image(1, 1, 0);
      set_shape(15'd2, 15'd2);
      send_image(2, 2, 0);
      drain();
      send_pixel(8'hA5);
      set_shape(15'd1, 15'd1);
      send_pixel(8'h3C);
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 85 : 0;
         recv_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 30 : 0;
         for (int k = 0; k < 8; k++) begin
            w = $urandom_range(3, 1);
            h = $urandom_range(4, 1);
            set_shape(15'(w), 15'(h));
            if (phase == 2 && k == 0) begin
               hold_off = 1'b1;
               fork
                  begin repeat (300) @(posedge clock); hold_off = 1'b0; end
                  send_image(w, h, 0);
               join
            end else begin
               send_image(w, h, 0);
            end
         end
      end
      set_shape(15'h7FFF, 15'd1);
      send_image(2, 1, 0);
      set_shape(15'd16384, 15'h7FFF);
      send_image(2, 1, 0);
      drain();
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

### png_idat_stored_deflate_framer_unit.f
rtl/pidat_pkg.sv
rtl/pidat_if.sv
rtl/pidat_queue.sv
rtl/pidat_back.sv
rtl/png_idat_stored_deflate_framer_unit.sv
verif/png_idat_stored_deflate_framer_unit_checker.sv
verif/tb_png_idat_stored_deflate_framer_unit.sv
